FILE: rtl/core/qs_pkg.sv
// Shared types and constants for the quaternion slerp pipeline.
// No dependencies; quaternion_slerp, qs_cordic and qs_div refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qs_pkg;

  // Q2.14 data, Q30 angles and weights
  localparam int FRAC_BITS = 14;
  localparam int WBITS     = 30;
  localparam int XW        = 34;   // CORDIC datapath width, signed

  localparam logic [14:0] ONE       = 15'(1 << FRAC_BITS);
  localparam logic [14:0] THR_RESET = 15'd16376;
  localparam logic [XW-1:0] INV_GAIN = XW'(652032874);

  // arctan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // Operands that ride along with every beat
  typedef struct packed {
    logic [3:0][16:0] a;   // start quaternion, sign-fixed, signed
    logic [3:0][15:0] b;   // end quaternion, signed
    logic [14:0]      t;   // clamped fraction
  } item_t;

  typedef struct packed {
    item_t       item;
    logic        gt;       // dot above threshold
    logic [30:0] d;        // clamped dot, Q30
  } root_side_t;

  typedef struct packed {
    item_t       item;
    logic        lin;      // take the linear blend
    logic [30:0] s;        // sin(theta), Q30
  } ang_side_t;

  typedef struct packed {
    logic        lin;
    logic [30:0] s;
  } wt_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/quaternion_slerp.sv
// Top level of the quaternion slerp pipeline.
// Depends on qs_pkg, qs_isqrt, qs_cordic and qs_div.
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined slerp of two Q2.14 unit quaternions. A beat enters on any
// cycle start is high (busy is always low), and its result shows on the out
// ports for exactly one cycle with done high. One beat per cycle is sustained
// without limit; the result side cannot stall and needs none. Latency is set by
// the 31-stage square root for sin(theta), the CORDIC angle and sine pipelines
// of CORDIC_STEPS stages each, and the 31-stage weight dividers. The threshold
// register takes a write on cfg_valid (cfg_ready is always high); write it
// only while no beats are in flight.
module quaternion_slerp #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] start_x,
  input  wire logic signed [15:0] start_y,
  input  wire logic signed [15:0] start_z,
  input  wire logic signed [15:0] start_w,
  input  wire logic signed [15:0] end_x,
  input  wire logic signed [15:0] end_y,
  input  wire logic signed [15:0] end_z,
  input  wire logic signed [15:0] end_w,
  input  wire logic [14:0]        fraction,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [14:0]        cfg_data,
  output logic                    done,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic signed [15:0]      out_w,
  output logic                    used_linear
);

  localparam int XW = qs_pkg::XW;
  localparam int FB = qs_pkg::FRAC_BITS;
  localparam int WB = qs_pkg::WBITS;
  localparam logic [61:0] RAD_ONE = 62'd1 << (2 * WB);

  // ---------------------------------------------------------------------
  // Handshake and threshold register
  // ---------------------------------------------------------------------
  logic        accept;
  logic [14:0] thr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qs_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: register the four component products, clamp t
  // ---------------------------------------------------------------------
  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];

  assign in_a[0] = start_x;
  assign in_a[1] = start_y;
  assign in_a[2] = start_z;
  assign in_a[3] = start_w;
  assign in_b[0] = end_x;
  assign in_b[1] = end_y;
  assign in_b[2] = end_z;
  assign in_b[3] = end_w;

  logic               s1_vld;
  logic signed [31:0] s1_prod [4];
  qs_pkg::item_t      s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      s1_prod[k]   <= in_a[k] * in_b[k];
      s1_item.a[k] <= {in_a[k][15], in_a[k]};
      s1_item.b[k] <= in_b[k];
    end
    s1_item.t <= (fraction > qs_pkg::ONE) ? qs_pkg::ONE : fraction;
  end

  // ---------------------------------------------------------------------
  // Stage 2: dot product, shorter-arc flip, clamp to 1.0, threshold test
  // ---------------------------------------------------------------------
  logic signed [33:0] dot;
  logic               dot_neg;
  logic [32:0]        adot;
  logic [28:0]        dq;

  assign dot = {{2{s1_prod[0][31]}}, s1_prod[0]} + {{2{s1_prod[1][31]}}, s1_prod[1]}
             + {{2{s1_prod[2][31]}}, s1_prod[2]} + {{2{s1_prod[3][31]}}, s1_prod[3]};
  assign dot_neg = dot[33];
  assign adot    = dot_neg ? 33'(-dot) : 33'(dot);
  assign dq      = (adot > (33'd1 << (2 * FB))) ? 29'(33'd1 << (2 * FB)) : adot[28:0];

  logic               s2_vld;
  qs_pkg::root_side_t s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      s2_side.item.a[k] <= dot_neg ? 17'(-$signed(s1_item.a[k])) : s1_item.a[k];
    end
    s2_side.item.b <= s1_item.b;
    s2_side.item.t <= s1_item.t;
    s2_side.gt     <= adot > {4'b0000, thr, 14'b0};
    s2_side.d      <= 31'(dq) << (WB - 2 * FB);
  end

  // ---------------------------------------------------------------------
  // Stage 3: square the clamped dot for 1 - d^2
  // ---------------------------------------------------------------------
  logic               s3_vld;
  logic [61:0]        s3_dsq;
  qs_pkg::root_side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_dsq  <= s2_side.d * s2_side.d;
    s3_side <= s2_side;
  end

  // ---------------------------------------------------------------------
  // sin(theta) = sqrt(1 - d^2)
  // ---------------------------------------------------------------------
  logic               rt_vld;
  logic [30:0]        rt_s;
  qs_pkg::root_side_t rt_side;

  qs_isqrt #(
    .SIDE_W ($bits(qs_pkg::root_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s3_vld),
    .in_val   (RAD_ONE - s3_dsq),
    .in_side  (s3_side),
    .out_vld  (rt_vld),
    .out_root (rt_s),
    .out_side (rt_side)
  );

  // Fall back to the linear blend above threshold or when the arc degenerates
  qs_pkg::ang_side_t rt_ang_side;

  assign rt_ang_side.item = rt_side.item;
  assign rt_ang_side.lin  = rt_side.gt || (rt_s == '0);
  assign rt_ang_side.s    = rt_s;

  // ---------------------------------------------------------------------
  // theta = atan2(s, d) by CORDIC vectoring
  // ---------------------------------------------------------------------
  logic                 th_vld;
  logic signed [XW-1:0] theta;
  qs_pkg::ang_side_t    th_side;

  qs_cordic #(
    .STEPS  (CORDIC_STEPS),
    .VECTOR (1'b1),
    .SIDE_W ($bits(qs_pkg::ang_side_t))
  ) u_cordic_angle (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rt_vld),
    .in_x     ($signed({3'b000, rt_side.d})),
    .in_y     ($signed({3'b000, rt_s})),
    .in_z     ('0),
    .in_side  (rt_ang_side),
    .out_vld  (th_vld),
    .out_res  (theta),
    .out_side (th_side)
  );

  // ---------------------------------------------------------------------
  // Scale stage: (1-t)*theta and t*theta, truncated to Q30
  // ---------------------------------------------------------------------
  logic [30:0]       th_pos;
  logic [45:0]       ang0_full;
  logic [45:0]       ang1_full;

  assign th_pos    = (theta > 0) ? theta[30:0] : '0;
  assign ang0_full = (qs_pkg::ONE - th_side.item.t) * th_pos;
  assign ang1_full = th_side.item.t * th_pos;

  logic              sc_vld;
  logic [30:0]       sc_ang0;
  logic [30:0]       sc_ang1;
  qs_pkg::ang_side_t sc_side;
  qs_pkg::wt_side_t  sc_wt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_vld <= 1'b0;
    end else begin
      sc_vld <= th_vld;
    end
  end

  always_ff @(posedge clk) begin
    sc_ang0 <= ang0_full[FB+30:FB];
    sc_ang1 <= ang1_full[FB+30:FB];
    sc_side <= th_side;
  end

  assign sc_wt.lin = sc_side.lin;
  assign sc_wt.s   = sc_side.s;

  // ---------------------------------------------------------------------
  // Sines of both partial angles, side by side
  // ---------------------------------------------------------------------
  logic                 sn0_vld;
  logic                 sn1_vld;
  logic signed [XW-1:0] sin0;
  logic signed [XW-1:0] sin1;
  qs_pkg::item_t        sn_item;
  qs_pkg::wt_side_t     sn_wt;

  qs_cordic #(
    .STEPS  (CORDIC_STEPS),
    .VECTOR (1'b0),
    .SIDE_W ($bits(qs_pkg::item_t))
  ) u_cordic_sin0 (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sc_vld),
    .in_x     ($signed(qs_pkg::INV_GAIN)),
    .in_y     ('0),
    .in_z     ($signed({3'b000, sc_ang0})),
    .in_side  (sc_side.item),
    .out_vld  (sn0_vld),
    .out_res  (sin0),
    .out_side (sn_item)
  );

  qs_cordic #(
    .STEPS  (CORDIC_STEPS),
    .VECTOR (1'b0),
    .SIDE_W ($bits(qs_pkg::wt_side_t))
  ) u_cordic_sin1 (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sc_vld),
    .in_x     ($signed(qs_pkg::INV_GAIN)),
    .in_y     ('0),
    .in_z     ($signed({3'b000, sc_ang1})),
    .in_side  (sc_wt),
    .out_vld  (sn1_vld),
    .out_res  (sin1),
    .out_side (sn_wt)
  );

  // ---------------------------------------------------------------------
  // Weights: sine / sin(theta)
  // ---------------------------------------------------------------------
  logic          w0_vld;
  logic          w1_vld;
  logic [30:0]   wq0;
  logic [30:0]   wq1;
  qs_pkg::item_t w_item;
  logic          w_lin;

  qs_div #(
    .SIDE_W ($bits(qs_pkg::item_t))
  ) u_div0 (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sn0_vld),
    .in_num   (sin0),
    .in_den   (sn_wt.s),
    .in_side  (sn_item),
    .out_vld  (w0_vld),
    .out_quo  (wq0),
    .out_side (w_item)
  );

  qs_div #(
    .SIDE_W (1)
  ) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sn1_vld),
    .in_num   (sin1),
    .in_den   (sn_wt.s),
    .in_side  (sn_wt.lin),
    .out_vld  (w1_vld),
    .out_quo  (wq1),
    .out_side (w_lin)
  );

  // Linear path reuses the blend: (1-t) and t lifted to Q30 round the same way
  logic [30:0] w0;
  logic [30:0] w1;

  assign w0 = w_lin ? (31'(qs_pkg::ONE - w_item.t) << (WB - FB)) : wq0;
  assign w1 = w_lin ? (31'(w_item.t) << (WB - FB)) : wq1;

  // ---------------------------------------------------------------------
  // Blend multiply stage
  // ---------------------------------------------------------------------
  logic               bm_vld;
  logic               bm_lin;
  logic signed [48:0] bm_m0 [4];
  logic signed [48:0] bm_m1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      bm_vld <= 1'b0;
    end else begin
      bm_vld <= w0_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      bm_m0[k] <= $signed({1'b0, w0}) * $signed(w_item.a[k]);
      bm_m1[k] <= 49'($signed({1'b0, w1}) * $signed(w_item.b[k]));
    end
    bm_lin <= w_lin;
  end

  // ---------------------------------------------------------------------
  // Sum, round to nearest, saturate, drive the result beat
  // ---------------------------------------------------------------------
  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    logic [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic signed [49:0] acc [4];
  logic [15:0]        res [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = {bm_m0[k][48], bm_m0[k]} + {bm_m1[k][48], bm_m1[k]}
             + (50'sd1 <<< (WB - 1));
      res[k] = sat16(20'(acc[k] >>> WB));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bm_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_x       <= res[0];
    out_y       <= res[1];
    out_z       <= res[2];
    out_w       <= res[3];
    used_linear <= bm_lin;
  end

`ifndef NO_ASSERTIONS
  // every result beat traces back to an accepted beat a fixed latency earlier
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 68 + 2 * CORDIC_STEPS))
    else $error("result beat without a matching input beat");

  // sin(theta) never exceeds 1.0 in Q30
  a_root_range : assert property (@(posedge clk) disable iff (rst)
    rt_vld |-> (rt_s <= (31'd1 << WB)))
    else $error("sqrt stage out of range");

  // both weight lanes stay aligned and capped at 1.0
  a_weight : assert property (@(posedge clk) disable iff (rst)
    w0_vld |-> (w1_vld && (wq0 <= (31'd1 << WB)) && (wq1 <= (31'd1 << WB))))
    else $error("weight lanes misaligned or above one");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/qs_isqrt.sv
// Pipelined integer square root, one result bit per stage (31 stages).
// Uses qs_pkg for nothing but keeps the house order; side data travels unchanged.
`timescale 1ns / 1ps
`default_nettype none

module qs_isqrt #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [61:0]       in_val,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [30:0]            out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int STAGES = 31;

  logic              vld  [STAGES];
  logic [31:0]       rem  [STAGES];
  logic [30:0]       root [STAGES];
  logic [61:0]       val  [STAGES];
  logic [SIDE_W-1:0] side [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic              vld_in;
    logic [31:0]       rem_in;
    logic [30:0]       root_in;
    logic [61:0]       val_in;
    logic [SIDE_W-1:0] side_in;
    logic [33:0]       rem_sh;
    logic [33:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = in_val;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[j-1];
      assign rem_in  = rem[j-1];
      assign root_in = root[j-1];
      assign val_in  = val[j-1];
      assign side_in = side[j-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in, val_in[61:60]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[j]  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
      root[j] <= {root_in[29:0], ge};
      val[j]  <= {val_in[59:0], 2'b00};
      side[j] <= side_in;
    end
  end

  assign out_vld  = vld[STAGES-1];
  assign out_root = root[STAGES-1];
  assign out_side = side[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/qs_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// Depends on qs_pkg for the datapath width and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module qs_cordic #(
  parameter int   STEPS  = 16,
  parameter bit   VECTOR = 1'b0,
  parameter int   SIDE_W = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_vld,
  input  wire logic signed [qs_pkg::XW-1:0]   in_x,
  input  wire logic signed [qs_pkg::XW-1:0]   in_y,
  input  wire logic signed [qs_pkg::XW-1:0]   in_z,
  input  wire logic [SIDE_W-1:0]              in_side,
  output logic                                out_vld,
  output logic signed [qs_pkg::XW-1:0]        out_res,
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int XW = qs_pkg::XW;

  logic                 vld  [STEPS];
  logic signed [XW-1:0] xr   [STEPS];
  logic signed [XW-1:0] yr   [STEPS];
  logic signed [XW-1:0] zr   [STEPS];
  logic [SIDE_W-1:0]    side [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                 vld_in;
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [XW-1:0] z_in;
    logic [SIDE_W-1:0]    side_in;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] at;
    logic                 ccw;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign x_in    = in_x;
      assign y_in    = in_y;
      assign z_in    = in_z;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[i-1];
      assign x_in    = xr[i-1];
      assign y_in    = yr[i-1];
      assign z_in    = zr[i-1];
      assign side_in = side[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = $signed({{(XW-32){1'b0}}, qs_pkg::ATAN_Q30[i]});

    // vectoring drives y toward zero, rotation drives z toward zero
    if (VECTOR) begin : g_vec
      assign ccw = !(y_in > 0);
    end else begin : g_rot
      assign ccw = !z_in[XW-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ccw) begin
        xr[i] <= x_in - ys;
        yr[i] <= y_in + xs;
        zr[i] <= z_in - at;
      end else begin
        xr[i] <= x_in + ys;
        yr[i] <= y_in - xs;
        zr[i] <= z_in + at;
      end
      side[i] <= side_in;
    end
  end

  assign out_vld  = vld[STEPS-1];
  assign out_res  = VECTOR ? zr[STEPS-1] : yr[STEPS-1];
  assign out_side = side[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/core/qs_div.sv
// Pipelined restoring divider for the slerp weights: floor(num * 2^30 / den), capped at 1.0.
// Depends on qs_pkg for WBITS and XW; one quotient bit per stage after a classify stage.
`timescale 1ns / 1ps
`default_nettype none

module qs_div #(
  parameter int SIDE_W = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_vld,
  input  wire logic signed [qs_pkg::XW-1:0] in_num,
  input  wire logic [30:0]                  in_den,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_vld,
  output logic [30:0]                       out_quo,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int QB     = qs_pkg::WBITS;
  localparam int STAGES = QB + 1;

  logic              vld  [STAGES];
  logic              zero [STAGES];
  logic              full [STAGES];
  logic [30:0]       rem  [STAGES];
  logic [30:0]       den  [STAGES];
  logic [QB-1:0]     quo  [STAGES];
  logic [SIDE_W-1:0] side [STAGES];

  // classify: sine at or below zero gives 0, sine at or above den gives 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    zero[0] <= in_num <= 0;
    full[0] <= (in_num > 0) && (in_num >= $signed({3'b000, in_den}));
    rem[0]  <= in_num[30:0];
    den[0]  <= in_den;
    quo[0]  <= '0;
    side[0] <= in_side;
  end

  for (genvar j = 1; j < STAGES; j++) begin : g_step
    logic [31:0] r2;
    logic        ge;

    assign r2 = {rem[j-1], 1'b0};
    assign ge = r2 >= {1'b0, den[j-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[j]  <= ge ? 31'(r2 - {1'b0, den[j-1]}) : r2[30:0];
      quo[j]  <= {quo[j-1][QB-2:0], ge};
      zero[j] <= zero[j-1];
      full[j] <= full[j-1];
      den[j]  <= den[j-1];
      side[j] <= side[j-1];
    end
  end

  assign out_vld  = vld[STAGES-1];
  assign out_quo  = zero[STAGES-1] ? '0 :
                    full[STAGES-1] ? 31'(1) << QB : {1'b0, quo[STAGES-1]};
  assign out_side = side[STAGES-1];

endmodule

`default_nettype wire

FILE: dv/tb_quaternion_slerp.sv
// Self-checking testbench for the quaternion_slerp pipeline: directed and random slerp beats,
// with an in-bench fixed-point slerp predictor. Depends on qs_pkg and the quaternion_slerp RTL.
`timescale 1ns / 1ps

module tb_quaternion_slerp;

  localparam int  N_RANDOM   = 650;
  localparam int  DRAIN_CYC  = 140;   // beyond the pipeline latency
  localparam int  MAX_MSGS   = 10;

  typedef struct {
    logic signed [15:0] q [4];
    logic               lin;
  } slerp_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] start_x = '0, start_y = '0, start_z = '0, start_w = '0;
  logic signed [15:0] end_x = '0, end_y = '0, end_z = '0, end_w = '0;
  logic [14:0] fraction = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;
  logic done;
  logic signed [15:0] out_x, out_y, out_z, out_w;
  logic used_linear;

  // predictor copy of the threshold register
  logic [14:0] lin_thr = qs_pkg::THR_RESET;

  slerp_res_t expected_q [$];
  int mismatches = 0;
  int n_results = 0;

  quaternion_slerp i_dut (
    .clk, .rst, .start, .busy,
    .start_x, .start_y, .start_z, .start_w,
    .end_x, .end_y, .end_z, .end_w, .fraction,
    .cfg_valid, .cfg_ready, .cfg_data,
    .done, .out_x, .out_y, .out_z, .out_w, .used_linear
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // floor shift for signed values, i.e. arithmetic shift right
  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += longint'(qs_pkg::ATAN_Q30[i]);
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= longint'(qs_pkg::ATAN_Q30[i]);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint rotate_sine(longint z);
    longint x, y, nx, ny;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= longint'(qs_pkg::ATAN_Q30[i]);
      end else begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += longint'(qs_pkg::ATAN_Q30[i]);
      end
      x = nx;
      y = ny;
    end
    return y;
  endfunction

  function automatic longint arc_weight(longint sn, longint s);
    if (sn <= 0) return 0;
    if (sn >= s) return longint'(1) << qs_pkg::WBITS;
    return (sn << qs_pkg::WBITS) / s;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic slerp_res_t predict_slerp(logic signed [15:0] qa [4],
                                               logic signed [15:0] qb [4],
                                               logic [14:0] frac);
    slerp_res_t r;
    longint a [4], b [4];
    longint dot, dq, d, s, t, one, acc, theta, ang0, ang1, w0, w1;
    one = longint'(1) << qs_pkg::FRAC_BITS;
    t = (frac > qs_pkg::ONE) ? one : longint'(frac);
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      a[k] = longint'(qa[k]);
      b[k] = longint'(qb[k]);
      dot += a[k] * b[k];
    end
    // flip the start quaternion so the blend follows the short arc
    if (dot < 0) begin
      for (int k = 0; k < 4; k++) a[k] = -a[k];
      dot = -dot;
    end
    dq = (dot > (longint'(1) << 28)) ? (longint'(1) << 28) : dot;
    d = dq << 2;
    s = root_floor((64'd1 << 60) - longint'(d * d));
    if (dot > (longint'(lin_thr) << qs_pkg::FRAC_BITS) || s == 0) begin
      for (int k = 0; k < 4; k++) begin
        acc = (one - t) * a[k] + t * b[k] + (longint'(1) << (qs_pkg::FRAC_BITS - 1));
        r.q[k] = clip16(shr_floor(acc, qs_pkg::FRAC_BITS));
      end
      r.lin = 1'b1;
    end else begin
      theta = vector_angle(d, s);
      if (theta < 0) theta = 0;
      ang0 = ((one - t) * theta) >>> qs_pkg::FRAC_BITS;
      ang1 = (t * theta) >>> qs_pkg::FRAC_BITS;
      w0 = arc_weight(rotate_sine(ang0), s);
      w1 = arc_weight(rotate_sine(ang1), s);
      for (int k = 0; k < 4; k++) begin
        acc = w0 * a[k] + w1 * b[k] + (longint'(1) << (qs_pkg::WBITS - 1));
        r.q[k] = clip16(shr_floor(acc, qs_pkg::WBITS));
      end
      r.lin = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  // Hold start for one beat; the block never raises busy, but honor it anyway.
  // Leaves start high; the caller lowers it when a gap is wanted.
  task automatic send_beat(logic signed [15:0] qa [4], logic signed [15:0] qb [4],
                           logic [14:0] frac);
    start    <= 1'b1;
    start_x  <= qa[0]; start_y <= qa[1]; start_z <= qa[2]; start_w <= qa[3];
    end_x    <= qb[0]; end_y   <= qb[1]; end_z   <= qb[2]; end_w   <= qb[3];
    fraction <= frac;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_slerp(qa, qb, frac));
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // bursty sender: occasionally drop start for a random gap
  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 12));
  endtask

  // wait until the pipeline has drained every beat in flight
  task automatic drain_pipe();
    int guard;
    pause_sender(1);
    guard = 0;
    while (expected_q.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lin_thr = value;
  endtask

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic signed [15:0] rand16();
    return 16'($urandom);
  endfunction

  // rough unit quaternion: random direction scaled near 16384
  task automatic rand_unit(output logic signed [15:0] q [4]);
    longint v [4];
    longint norm;
    norm = 0;
    for (int k = 0; k < 4; k++) begin
      v[k] = longint'($urandom_range(0, 32766)) - 16383;
      norm += v[k] * v[k];
    end
    norm = root_floor(norm);
    if (norm == 0) norm = 1;
    for (int k = 0; k < 4; k++) q[k] = 16'((v[k] * 16384) / norm);
  endtask

  // nudge a quaternion by a small amount so the dot product sits near one
  task automatic perturb(input logic signed [15:0] src [4], output logic signed [15:0] q [4],
                         input int spread);
    for (int k = 0; k < 4; k++)
      q[k] = 16'(longint'(src[k]) + $urandom_range(0, 2 * spread) - spread);
  endtask

  function automatic logic [14:0] rand_fraction();
    case ($urandom_range(0, 9))
      0:       return 15'd0;
      1:       return qs_pkg::ONE;
      2:       return 15'($urandom_range(16385, 32767));   // clamped to one
      default: return 15'($urandom_range(0, 16384));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic signed [15:0] qa [4], qb [4];
    // identity to identity: dot exactly one, zero sine forces the linear path
    qa = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_beat(qa, qa, 15'd8192);
    // orthogonal pair at the ends and middle of t, and with t above one
    qb = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    send_beat(qa, qb, 15'd0);
    send_beat(qa, qb, qs_pkg::ONE);
    send_beat(qa, qb, 15'd8192);
    send_beat(qa, qb, 15'h7FFF);
    // opposite and obtuse pairs: negative dot flips the start
    qb = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384};
    send_beat(qa, qb, 15'd4096);
    qb = '{16'sd0, -16'sd11585, 16'sd0, -16'sd11585};
    send_beat(qa, qb, 15'd12000);
    // field extremes: non-unit inputs, dot above one and saturation
    qa = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    send_beat(qa, qa, 15'd5000);
    qb = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_beat(qa, qb, 15'd10000);
    send_beat(qb, qb, 15'd0);
    qb = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1};
    send_beat(qa, qb, 15'd1);
    send_beat(qb, qa, 15'd16383);
    // near parallel, just either side of the reset threshold
    qa = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    qb = '{16'sd300, 16'sd0, 16'sd0, 16'sd16381};
    send_beat(qa, qb, 15'd8192);
    qb = '{16'sd600, 16'sd0, 16'sd0, 16'sd16373};
    send_beat(qa, qb, 15'd8192);
    // all zero: dot zero, theta a right angle, weights from zero quaternions
    qa = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_beat(qa, qa, 15'd3000);
    drain_pipe();
  endtask

  task automatic run_random(int count);
    logic signed [15:0] qa [4], qb [4];
    for (int n = 0; n < count; n++) begin
      rand_unit(qa);
      case ($urandom_range(0, 9))
        0, 1:    perturb(qa, qb, $urandom_range(1, 400));      // near parallel
        2:       for (int k = 0; k < 4; k++) qb[k] = -qa[k];   // antipodal-ish
        3: begin                                               // raw noise
          for (int k = 0; k < 4; k++) begin
            qa[k] = rand16();
            qb[k] = rand16();
          end
        end
        default: rand_unit(qb);
      endcase
      send_beat(qa, qb, rand_fraction());
      maybe_gap();
    end
    drain_pipe();
  endtask

  task automatic test_threshold_sweep();
    logic [14:0] settings [5];
    settings = '{15'd0, 15'd16384, 15'h7FFF, 15'd12000, qs_pkg::THR_RESET};
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      run_random(N_RANDOM / 10);
    end
  endtask

  // ---------------------------------------------------------------- checking
  // Results cannot be held off; sample every cycle with done high.
  always @(posedge clk) begin
    slerp_res_t exp_r;
    logic signed [15:0] got [4];
    if (!rst && done) begin
      got = '{out_x, out_y, out_z, out_w};
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MSGS)
          $display("[%0t] unexpected result beat: %0d %0d %0d %0d lin=%0b",
                   $realtime, out_x, out_y, out_z, out_w, used_linear);
      end else begin
        exp_r = expected_q.pop_front();
        if (got != exp_r.q || used_linear !== exp_r.lin) begin
          mismatches++;
          if (mismatches <= MAX_MSGS)
            $display("[%0t] beat %0d exp (%0d %0d %0d %0d lin=%0b) got (%0d %0d %0d %0d lin=%0b)",
                     $realtime, n_results, exp_r.q[0], exp_r.q[1], exp_r.q[2], exp_r.q[3],
                     exp_r.lin, out_x, out_y, out_z, out_w, used_linear);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_random(N_RANDOM / 2);
    test_threshold_sweep();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
